// File: design/cfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg - clock frame replacement shared definitions
// Word types, request codes and the command/status structs of the frame cells.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int REQ_W          = 2;
    localparam int FRAME_W        = 6;   // frame field on the ports
    localparam int PAGE_W         = 36;  // virtual page number, VA bits 47..12
    localparam int POS_W          = 8;   // enough for the largest frame count (256)
    localparam int FRAMES_DEFAULT = 64;

    typedef logic [REQ_W-1:0]   t_req;
    typedef logic [FRAME_W-1:0] t_frame_field;
    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [POS_W-1:0]   t_pos;

    // request codes
    localparam t_req REQ_TOUCH   = 2'd0;
    localparam t_req REQ_FAULT   = 2'd1;
    localparam t_req REQ_RELEASE = 2'd2;

    typedef struct packed {
        t_req         req_type;
        t_frame_field frame_index;
        t_page        page_number;
    } t_in_word;

    typedef struct packed {
        t_frame_field granted_frame;
        logic         evicted;
        t_page        victim_page;
    } t_out_word;

    // cell command codes
    localparam int CMD_W = 3;
    typedef logic [CMD_W-1:0] t_cmd_op;
    localparam t_cmd_op CMD_NONE       = 3'd0;
    localparam t_cmd_op CMD_TOUCH      = 3'd1;
    localparam t_cmd_op CMD_RELEASE    = 3'd2;
    localparam t_cmd_op CMD_START      = 3'd3;  // drop the scan token at target
    localparam t_cmd_op CMD_SCAN_FREE  = 3'd4;  // token looks for a free frame
    localparam t_cmd_op CMD_SCAN_CLOCK = 3'd5;  // token runs the second-chance sweep
    localparam t_cmd_op CMD_CLAIM      = 3'd6;  // token holder becomes busy

    typedef struct packed {
        t_cmd_op op;
        t_pos    target;
    } t_cell_cmd;

    typedef struct packed {
        logic token;
        logic busy;
        logic hit;
    } t_cell_stat;

endpackage : cfr_pkg
`default_nettype wire

// File: design/cfr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_cell - one physical frame of the replacement ring
// Holds busy and accessed bits plus the scan token; passes the token to the
// next cell when the scan condition says to move on.
// ----------------------------------------------------------------------------
module cfr_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cfr_pkg::t_cell_cmd i_cmd,
    input  wire logic               i_pass,   // token from the left neighbor
    output logic                    o_pass,   // token to the right neighbor
    output cfr_pkg::t_cell_stat     o_stat
);

    logic r_busy, r_accessed, r_token;
    logic n_busy, n_accessed, n_token;
    logic w_sel, w_scan, w_cond;

    assign w_sel  = (i_cmd.target == cfr_pkg::t_pos'(CELL_INDEX));
    assign w_scan = (i_cmd.op == cfr_pkg::CMD_SCAN_FREE) ||
                    (i_cmd.op == cfr_pkg::CMD_SCAN_CLOCK);

    // condition for the token to move on
    always_comb begin
        case (i_cmd.op)
            cfr_pkg::CMD_SCAN_FREE:  w_cond = r_busy;
            cfr_pkg::CMD_SCAN_CLOCK: w_cond = r_busy & r_accessed;
            default:                 w_cond = 1'b0;
        endcase
    end

    assign o_pass       = w_scan & r_token & w_cond;
    assign o_stat.hit   = w_scan & r_token & ~w_cond;
    assign o_stat.token = r_token;
    assign o_stat.busy  = r_busy;

    always_comb begin
        n_busy     = r_busy;
        n_accessed = r_accessed;
        n_token    = r_token;
        case (i_cmd.op)
            cfr_pkg::CMD_TOUCH: begin
                if (w_sel && r_busy) begin
                    n_accessed = 1'b1;
                end
            end
            cfr_pkg::CMD_RELEASE: begin
                if (w_sel) begin
                    n_busy     = 1'b0;
                    n_accessed = 1'b0;
                end
            end
            cfr_pkg::CMD_START: begin
                n_token = w_sel;
            end
            cfr_pkg::CMD_SCAN_FREE: begin
                n_token = i_pass | (r_token & ~w_cond);
            end
            cfr_pkg::CMD_SCAN_CLOCK: begin
                n_token = i_pass | (r_token & ~w_cond);
                if (o_pass) begin
                    n_accessed = 1'b0;  // second chance used up
                end
            end
            cfr_pkg::CMD_CLAIM: begin
                if (r_token) begin
                    n_busy     = 1'b1;
                    n_accessed = 1'b0;
                    n_token    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_accessed <= 1'b0;
            r_token    <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_accessed <= n_accessed;
            r_token    <= n_token;
        end
    end

endmodule : cfr_cell
`default_nettype wire

// File: design/clock_frame_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_frame_replacement_core - clock (second-chance) frame allocator
// Ring of frame cells with a circulating scan token, plus an owner-page RAM.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall       | word                     | dir
//  --------+-------------+-------------+--------------------------+-----
//  request | i_in_valid  | o_in_stall  | i_in_word  (t_in_word)   | in
//  result  | o_out_valid | i_out_stall | o_out_word (t_out_word)  | out
//
//  Sequence: a request is taken only in S_IDLE; touch, release and unknown ones
//  then pass S_EXEC and S_DONE, a fault S_EXEC, S_SCAN, S_HIT and S_DONE. The
//  scan stops at the lowest free frame or, with none free, at the first frame
//  from the hand on with a clear accessed bit. The token moves one cell per cycle.
//  Reset (synchronous, active low) frees every frame, clears accessed bits
//  and puts the hand at frame 0; the owner RAM is not cleared.
//  A result word waits in the output register; a stall there holds the
//  block only once the next result is ready.
//
module clock_frame_replacement_core #(
    parameter int FRAMES = cfr_pkg::FRAMES_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cfr_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cfr_pkg::t_out_word     o_out_word
);

    localparam int PW = $clog2(FRAMES);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;  // decode, issue touch/release or start scan
    localparam logic [2:0] S_SCAN = 3'd2;  // token walks the ring
    localparam logic [2:0] S_HIT  = 3'd3;  // claim frame, write owner
    localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

    logic [2:0]          r_state, n_state;
    cfr_pkg::t_in_word   r_req;
    logic [PW-1:0]       r_pos, n_pos;      // frame under the token
    logic [PW-1:0]       r_hand, n_hand;    // clock hand
    logic                r_clock, n_clock;  // scan is a clock sweep
    cfr_pkg::t_out_word  r_res, n_res;
    logic                r_out_valid, n_out_valid;
    cfr_pkg::t_out_word  r_out_word;
    cfr_pkg::t_page      r_rd_page;

    cfr_pkg::t_page      r_page_mem [FRAMES];

    cfr_pkg::t_cell_cmd  w_cmd;
    cfr_pkg::t_cell_stat w_stat [FRAMES];
    logic [FRAMES-1:0]   w_pass;
    logic [FRAMES-1:0]   w_busy;
    logic [FRAMES-1:0]   w_hit;
    logic [FRAMES-1:0]   w_token;
    logic                w_any_free;
    logic                w_any_hit;
    logic                w_accept;
    logic [PW-1:0]       w_pos_next;

    // ---------------- frame ring ----------------
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        cfr_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_pass  (w_pass[(g + FRAMES - 1) % FRAMES]),
            .o_pass  (w_pass[g]),
            .o_stat  (w_stat[g])
        );
        assign w_busy[g]  = w_stat[g].busy;
        assign w_hit[g]   = w_stat[g].hit;
        assign w_token[g] = w_stat[g].token;
    end

    assign w_any_free = ~&w_busy;
    assign w_any_hit  = |w_hit;
    assign w_pos_next = (r_pos == PW'(FRAMES - 1)) ? '0 : r_pos + 1'b1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------- cell commands ----------------
    always_comb begin
        w_cmd.op     = cfr_pkg::CMD_NONE;
        w_cmd.target = '0;
        case (r_state)
            S_EXEC: begin
                case (r_req.req_type)
                    cfr_pkg::REQ_TOUCH: begin
                        w_cmd.op     = cfr_pkg::CMD_TOUCH;
                        w_cmd.target = cfr_pkg::t_pos'(r_req.frame_index);
                    end
                    cfr_pkg::REQ_RELEASE: begin
                        w_cmd.op     = cfr_pkg::CMD_RELEASE;
                        w_cmd.target = cfr_pkg::t_pos'(r_req.frame_index);
                    end
                    cfr_pkg::REQ_FAULT: begin
                        // lowest free frame scan starts at 0, else sweep from hand
                        w_cmd.op     = cfr_pkg::CMD_START;
                        w_cmd.target = w_any_free ? '0 : cfr_pkg::t_pos'(r_hand);
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                w_cmd.op = r_clock ? cfr_pkg::CMD_SCAN_CLOCK : cfr_pkg::CMD_SCAN_FREE;
            end
            S_HIT: begin
                w_cmd.op = cfr_pkg::CMD_CLAIM;
            end
            default: begin
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_hand      = r_hand;
        n_clock     = r_clock;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res = '0;
                if (r_req.req_type == cfr_pkg::REQ_FAULT) begin
                    n_clock = !w_any_free;
                    n_pos   = w_any_free ? '0 : r_hand;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (w_any_hit) begin
                    n_state = S_HIT;
                end else begin
                    n_pos = w_pos_next;
                end
            end
            S_HIT: begin
                n_res.granted_frame = cfr_pkg::t_frame_field'(r_pos);
                n_res.evicted       = r_clock;
                n_res.victim_page   = r_clock ? r_rd_page : '0;
                if (r_clock) begin
                    n_hand = w_pos_next;  // hand moves past the victim
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hand      <= '0;
            r_pos       <= '0;
            r_clock     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hand      <= n_hand;
            r_pos       <= n_pos;
            r_clock     <= n_clock;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_word;
        end
        r_res <= n_res;
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_word <= r_res;
        end
    end

    // owner-page RAM: read while scanning, write the new owner on claim
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_rd_page <= r_page_mem[r_pos];
        end
        if (r_state == S_HIT) begin
            r_page_mem[r_pos] <= r_req.page_number;
        end
    end

    // ---------------- assertions ----------------
    a_token_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_token))
        else $error("more than one scan token in the ring");

    a_token_at_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> w_token[r_pos])
        else $error("scan token and position counter disagree");

    a_claim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT) |=> w_busy[$past(r_pos)])
        else $error("granted frame not marked busy");

    a_free_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !r_clock && w_any_hit) |-> !w_busy[r_pos])
        else $error("free scan stopped on a busy frame");

endmodule : clock_frame_replacement_core
`default_nettype wire

// File: tb/clock_frame_replacement_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_frame_replacement_core_tb - self-checking bench for the frame allocator
// Sends touch, fault and release words in bursts and stalls the result side on
// its own pattern. A scoreboard keeps its own frame table and clock hand and
// checks each result word in order.
// ----------------------------------------------------------------------------
module clock_frame_replacement_core_tb;
    import cfr_pkg::*;

    localparam int   N_FRAMES     = FRAMES_DEFAULT;
    localparam t_req REQ_UNKNOWN  = 2'd3;  // no operation, result is all zero
    localparam int   RANDOM_WORDS = 1150;
    localparam int   HOLD_OFF     = 300;   // long result-side stall, in cycles
    localparam int   DRAIN_CYCLES = 20;    // settle time after the last result

    // Watchdog: the slowest single step is a fault that sweeps a full pass,
    // plus the hold-off above, plus a random sender gap. QUIET_LIMIT quiet
    // cycles is many times that.
    localparam int   QUIET_LIMIT  = 4000;

    typedef enum int {
        SEQ_FAULTS,
        SEQ_TOUCHES,
        SEQ_RELEASES,
        SEQ_TOUCH_ALL,
        SEQ_DRAIN,
        SEQ_NOISE
    } t_seq_kind;

    // ------------------------------------------------------------------------
    // Scoreboard: frame table plus clock hand, one expected word per request.
    // ------------------------------------------------------------------------
    class frame_grant_board;
        bit        busy     [N_FRAMES];
        bit        accessed [N_FRAMES];
        t_page     owner    [N_FRAMES];
        int        hand;
        t_out_word grants_due [$];
        int        words_taken;
        int        failures;

        function new();
            foreach (busy[i]) begin
                busy[i]     = 1'b0;
                accessed[i] = 1'b0;
                owner[i]    = '0;
            end
            hand        = 0;
            words_taken = 0;
            failures    = 0;
        endfunction

        function int step_hand(int h);
            return (h + 1 >= N_FRAMES) ? 0 : h + 1;
        endfunction

        function int free_frames();
            int n;
            n = 0;
            foreach (busy[i])
                if (!busy[i]) n++;
            return n;
        endfunction

        function void note_request(t_in_word w);
            t_out_word res;
            int        f;
            int        i;
            res = '0;
            words_taken++;
            case (w.req_type)
                REQ_TOUCH: begin
                    // touching a free frame leaves it alone
                    if (w.frame_index < N_FRAMES && busy[w.frame_index])
                        accessed[w.frame_index] = 1'b1;
                end
                REQ_FAULT: begin
                    f = -1;
                    for (i = N_FRAMES - 1; i >= 0; i--)
                        if (!busy[i]) f = i;
                    if (f < 0) begin
                        // second chance: clear accessed bits until a clear one
                        while (accessed[hand]) begin
                            accessed[hand] = 1'b0;
                            hand = step_hand(hand);
                        end
                        f               = hand;
                        res.evicted     = 1'b1;
                        res.victim_page = owner[f];
                        hand            = step_hand(hand);
                    end
                    busy[f]           = 1'b1;
                    accessed[f]       = 1'b0;
                    owner[f]          = w.page_number;
                    res.granted_frame = t_frame_field'(f);
                end
                REQ_RELEASE: begin
                    if (w.frame_index < N_FRAMES) begin
                        busy[w.frame_index]     = 1'b0;
                        accessed[w.frame_index] = 1'b0;
                    end
                end
                default: ;
            endcase
            grants_due.push_back(res);
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                failures++;
                return;
            end
            want = grants_due.pop_front();
            if (got.granted_frame !== want.granted_frame) begin
                $display("%0t: granted_frame expected %0d got %0d",
                         $time, want.granted_frame, got.granted_frame);
                failures++;
            end
            if (got.evicted !== want.evicted) begin
                $display("%0t: evicted expected %0b got %0b", $time, want.evicted, got.evicted);
                failures++;
            end
            if (got.victim_page !== want.victim_page) begin
                $display("%0t: victim_page expected %h got %h",
                         $time, want.victim_page, got.victim_page);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    clock_frame_replacement_core #(
        .FRAMES (N_FRAMES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    frame_grant_board board;
    int               burst_left;
    int               useful_words;
    int               quiet_cycles;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic t_page rand_page();
        t_page p;
        p[35:32] = 4'($urandom_range(0, 15));
        p[31:0]  = $urandom;
        return p;
    endfunction

    function automatic t_in_word make_word(t_req r, int idx, t_page p);
        t_in_word w;
        w.req_type    = r;
        w.frame_index = t_frame_field'(idx);
        w.page_number = p;
        return w;
    endfunction

    // Sends one word. Bursts of random length, random gaps in between; some
    // bursts start with no gap at all so long back-to-back runs happen too.
    task automatic issue(t_in_word w);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 10)) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        // word is held steady while stalled
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(w);
        if (w.req_type != REQ_UNKNOWN) useful_words++;
    endtask

    initial begin
        t_seq_kind kind;
        int        pick;
        int        first;
        int        i;
        board        = new();
        burst_left   = 0;
        useful_words = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // -- directed --
        issue(make_word(REQ_TOUCH,   0,  '0));             // touch of a free frame
        issue(make_word(REQ_RELEASE, 63, '0));             // release of a free frame
        issue(make_word(REQ_UNKNOWN, 63, '1));             // unknown request
        issue(make_word(REQ_FAULT,   63, '1));             // frame 0, max page
        issue(make_word(REQ_FAULT,   0,  '0));             // frame 1, page zero
        issue(make_word(REQ_FAULT,   21, 36'hA_5A5A_5A5A));
        issue(make_word(REQ_TOUCH,   1,  36'h5_A5A5_A5A5)); // touch of a busy frame
        issue(make_word(REQ_TOUCH,   63, '1));             // free, top index
        issue(make_word(REQ_RELEASE, 1,  '1));             // busy and accessed
        issue(make_word(REQ_FAULT,   42, 36'h5_A5A5_A5A5)); // refills lowest free
        issue(make_word(REQ_RELEASE, 0,  '0));
        issue(make_word(REQ_RELEASE, 0,  '1));             // second release: no effect
        issue(make_word(REQ_FAULT,   0,  36'h8_0000_0001));
        issue(make_word(REQ_UNKNOWN, 0,  '0));
        issue(make_word(REQ_TOUCH,   2,  '1));

        // -- random --
        // Start by filling every frame, marking all accessed and faulting once:
        // the sweep clears a whole pass before it finds a victim.
        useful_words = 0;
        while (board.free_frames() != 0)
            issue(make_word(REQ_FAULT, $urandom_range(0, 63), rand_page()));
        first = $urandom_range(0, N_FRAMES - 1);
        for (i = 0; i < N_FRAMES; i++)
            issue(make_word(REQ_TOUCH, (first + i) % N_FRAMES, rand_page()));
        issue(make_word(REQ_FAULT, $urandom_range(0, 63), rand_page()));

        // Faults outweigh releases so the table stays mostly full and the
        // hand keeps moving; an occasional drain empties it for a refill.
        while (useful_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)      kind = SEQ_TOUCHES;
            else if (pick < 68) kind = SEQ_FAULTS;
            else if (pick < 83) kind = SEQ_RELEASES;
            else if (pick < 86) kind = SEQ_TOUCH_ALL;
            else if (pick < 88) kind = SEQ_DRAIN;
            else                kind = SEQ_NOISE;
            first = $urandom_range(0, N_FRAMES - 1);
            case (kind)
                SEQ_FAULTS: begin
                    repeat ($urandom_range(1, 8))
                        issue(make_word(REQ_FAULT, $urandom_range(0, 63), rand_page()));
                end
                SEQ_TOUCHES: begin
                    repeat ($urandom_range(1, 16))
                        issue(make_word(REQ_TOUCH, $urandom_range(0, 63), rand_page()));
                end
                SEQ_RELEASES: begin
                    repeat ($urandom_range(1, 4))
                        issue(make_word(REQ_RELEASE, $urandom_range(0, 63), rand_page()));
                end
                SEQ_TOUCH_ALL: begin
                    for (i = 0; i < N_FRAMES; i++)
                        issue(make_word(REQ_TOUCH, (first + i) % N_FRAMES, rand_page()));
                    issue(make_word(REQ_FAULT, $urandom_range(0, 63), rand_page()));
                end
                SEQ_DRAIN: begin
                    for (i = 0; i < N_FRAMES; i++)
                        issue(make_word(REQ_RELEASE, (first + i) % N_FRAMES, rand_page()));
                end
                default: begin
                    repeat ($urandom_range(1, 3))
                        issue(make_word(t_req'($urandom_range(0, 3)), $urandom_range(0, 63),
                                        rand_page()));
                end
            endcase
        end

        // drop valid right away so the last word is not taken twice
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (board.grants_due.size() != 0) @(posedge i_clk);
        // any stray word in this window is flagged by the monitor
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern in stretches, plus one long hold-off that
    // lets the output register fill and back up into the request side.
    // ------------------------------------------------------------------------
    initial begin
        int mode;
        bit held;
        i_out_stall = 1'b0;
        held        = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && board.words_taken >= 400) begin
                held = 1'b1;
                repeat (HOLD_OFF) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(8, 60)) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    default: i_out_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out_word);
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no word accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
